// ===== sv/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

  // longest search pattern and longest replacement, in bytes
  localparam int unsigned MAX_PATTERN = 8;
  localparam int unsigned REPLACE_MAX = 8;
  localparam int unsigned LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_ADDR_W  = 5;

  // register map, one 64-bit register every 8 bytes
  typedef enum logic [1:0] {
    REG_SEARCH_PATTERN  = 2'd0,
    REG_SEARCH_LENGTH   = 2'd1,
    REG_REPLACE_PATTERN = 2'd2,
    REG_REPLACE_LENGTH  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;
  } out_item_t;

endpackage

// ===== sv/stream_find_and_replace_unit.sv =====
`timescale 1ns / 1ps

// Stream find-and-replace.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one text byte per
// transaction, with stream_last marking the final byte of a stream. The
// output channel (out_valid_o/out_ready_i/out_data_o) returns the
// substituted text one byte per transaction; run_last flags the final
// result caused by an input byte and stream_end the final result of the
// stream. A stream end that leaves nothing to emit gives one bare marker
// with byte_valid low.
// An accepted byte is compared against the window in the same cycle and its
// results (0 to 8) are loaded into a result buffer; the first one is
// offered on the next cycle. A new byte is accepted in the cycle the
// previous byte's last result is taken, so a byte that yields several
// results holds off the input until all of them are taken, which bounds
// the rate.
// The APB port sets the patterns and lengths; writing the search length
// empties the window. Reset clears the registers, the window count and the
// count of buffered results. When the receiver stalls the buffered result holds and the
// input is held off once the buffer is not about to empty.
module stream_find_and_replace_unit
  import sfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // input stream
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  // output stream
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  logic [CFG_DATA_W-1:0] search_pat_q, replace_pat_q;
  logic [3:0]            search_len_q, replace_len_q;
  logic [7:0]            win_q [MAX_PATTERN];
  logic [LEN_W-1:0]      wcnt_q, wcnt_d;
  logic [7:0]            res_q [MAX_PATTERN];
  logic [7:0]            res_d [MAX_PATTERN];
  logic [LEN_W-1:0]      rem_q, n_d;
  logic                  bvalid_q, bvalid_d;
  logic                  blast_q, blast_d;
  logic [7:0]            w [MAX_PATTERN];
  logic [LEN_W-1:0]      slen, rlen, c1;
  logic                  mism;
  logic                  in_fire, out_fire, cfg_wr;
  cfg_reg_e              reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_e'(paddr[4:3]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_SEARCH_PATTERN:  prdata = search_pat_q;
      REG_SEARCH_LENGTH:   prdata = {{(CFG_DATA_W-4){1'b0}}, search_len_q};
      REG_REPLACE_PATTERN: prdata = replace_pat_q;
      REG_REPLACE_LENGTH:  prdata = {{(CFG_DATA_W-4){1'b0}}, replace_len_q};
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_pat_q  <= '0;
      search_len_q  <= '0;
      replace_pat_q <= '0;
      replace_len_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SEARCH_PATTERN:  search_pat_q  <= pwdata;
        REG_SEARCH_LENGTH:   search_len_q  <= pwdata[3:0];
        REG_REPLACE_PATTERN: replace_pat_q <= pwdata;
        REG_REPLACE_LENGTH:  replace_len_q <= pwdata[3:0];
      endcase
    end
  end

  // effective lengths, oversized values saturate
  assign slen = (search_len_q > 4'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                  : LEN_W'(search_len_q);
  assign rlen = (replace_len_q > 4'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX)
                                                   : LEN_W'(replace_len_q);

  // handshakes
  assign out_valid_o = (rem_q != '0);
  assign out_fire    = out_valid_o & out_ready_i;
  assign in_ready_o  = (rem_q == '0) | ((rem_q == LEN_W'(1)) & out_ready_i);
  assign in_fire     = in_valid_i & in_ready_o;

  // window with the new byte appended
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      w[i] = ((wcnt_q < LEN_W'(MAX_PATTERN)) && (wcnt_q[LEN_W-2:0] == (LEN_W-1)'(i)))
             ? in_data_i.data_byte : win_q[i];
    end
    c1 = (wcnt_q < LEN_W'(MAX_PATTERN)) ? wcnt_q + LEN_W'(1) : wcnt_q;
  end

  // pattern compare over the first slen window bytes
  always_comb begin
    mism = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) < slen) && (w[i] != search_pat_q[8*i +: 8])) mism = 1'b1;
    end
  end

  // results of one input transaction and the next window count
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) res_d[i] = w[i];
    n_d      = '0;
    wcnt_d   = wcnt_q;
    bvalid_d = 1'b1;
    blast_d  = in_data_i.stream_last;
    if (slen == '0) begin
      // pass-through
      res_d[0] = in_data_i.data_byte;
      n_d      = LEN_W'(1);
    end else if (c1 >= slen) begin
      if (!mism) begin
        // match: emit replacement, window empties
        for (int i = 0; i < MAX_PATTERN; i++) res_d[i] = replace_pat_q[8*i +: 8];
        n_d    = rlen;
        wcnt_d = '0;
      end else if (in_data_i.stream_last) begin
        // oldest byte plus flush of the rest
        n_d    = c1;
        wcnt_d = '0;
      end else begin
        n_d    = LEN_W'(1);
        wcnt_d = c1 - LEN_W'(1);
      end
    end else if (in_data_i.stream_last) begin
      // short tail cannot match
      n_d    = c1;
      wcnt_d = '0;
    end else begin
      wcnt_d = c1;
    end
    // bare end marker
    if (in_data_i.stream_last && (n_d == '0)) begin
      res_d[0] = 8'h00;
      n_d      = LEN_W'(1);
      bvalid_d = 1'b0;
    end
  end

  // window contents, shifted by one when the oldest byte leaves
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        win_q[i] <= (c1 >= slen && mism) ? w[i+1] : w[i];
      end
      win_q[MAX_PATTERN-1] <= w[MAX_PATTERN-1];
    end
  end

  // window count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q <= '0;
    end else if (cfg_wr && reg_idx == REG_SEARCH_LENGTH) begin
      wcnt_q <= '0;
    end else if (in_fire) begin
      wcnt_q <= wcnt_d;
    end
  end

  // result buffer payload, drains from entry 0
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_PATTERN; i++) res_q[i] <= res_d[i];
      bvalid_q <= bvalid_d;
      blast_q  <= blast_d;
    end else if (out_fire) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) res_q[i] <= res_q[i+1];
    end
  end

  // results still to deliver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (in_fire) begin
      rem_q <= n_d;
    end else if (out_fire) begin
      rem_q <= rem_q - LEN_W'(1);
    end
  end

  // output transaction
  always_comb begin
    out_data_o.out_byte   = res_q[0];
    out_data_o.byte_valid = bvalid_q;
    out_data_o.run_last   = (rem_q == LEN_W'(1));
    out_data_o.stream_end = (rem_q == LEN_W'(1)) & blast_q;
  end

endmodule

// ===== test/tb_stream_find_and_replace_unit.sv =====
`timescale 1ns / 1ps

module tb_stream_find_and_replace_unit;
  import sfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned IDLE_PCT    = 23;

  // scoreboard: substitution predictor and store of expected output bytes
  class substitution_scoreboard;
    logic [63:0] search_pat;
    logic [3:0]  search_len;
    logic [63:0] replace_pat;
    logic [3:0]  replace_len;
    logic [7:0]  window[MAX_PATTERN];
    int unsigned win_count;
    out_item_t   expected_out[$];
    int unsigned mismatches;

    function new();
      search_pat  = '0;
      search_len  = '0;
      replace_pat = '0;
      replace_len = '0;
      win_count   = 0;
      mismatches  = 0;
    endfunction

    function void set_register(cfg_reg_e r, logic [63:0] v);
      case (r)
        REG_SEARCH_PATTERN: search_pat = v;
        // a new search length drops whatever the window holds
        REG_SEARCH_LENGTH: begin
          search_len = v[3:0];
          win_count  = 0;
        end
        REG_REPLACE_PATTERN: replace_pat = v;
        REG_REPLACE_LENGTH: replace_len = v[3:0];
        default: ;
      endcase
    endfunction

    // work out the output bytes caused by one accepted input transaction
    function void note_byte(in_item_t it);
      out_item_t   res[$];
      out_item_t   o;
      int unsigned slen;
      int unsigned rlen;
      bit          hit;
      slen = (search_len > MAX_PATTERN) ? MAX_PATTERN : search_len;
      rlen = (replace_len > REPLACE_MAX) ? REPLACE_MAX : replace_len;
      o = '0;
      o.byte_valid = 1'b1;
      if (slen == 0) begin
        o.out_byte = it.data_byte;
        res.push_back(o);
      end else begin
        if (win_count < MAX_PATTERN) begin
          window[win_count] = it.data_byte;
          win_count++;
        end
        if (win_count >= slen) begin
          hit = 1'b1;
          for (int i = 0; i < slen; i++)
            if (window[i] != search_pat[8*i +: 8]) hit = 1'b0;
          if (hit) begin
            for (int i = 0; i < rlen; i++) begin
              o.out_byte = replace_pat[8*i +: 8];
              res.push_back(o);
            end
            win_count = 0;
          end else begin
            o.out_byte = window[0];
            res.push_back(o);
            for (int i = 1; i < win_count; i++) window[i-1] = window[i];
            win_count--;
          end
        end
        // end of stream flushes the short tail as it is
        if (it.stream_last) begin
          for (int i = 0; i < win_count; i++) begin
            o.out_byte = window[i];
            res.push_back(o);
          end
          win_count = 0;
        end
      end
      // bare end marker when the stream ends with nothing to emit
      if (it.stream_last && res.size() == 0) res.push_back(out_item_t'('0));
      if (res.size() > 0) begin
        res[res.size()-1].run_last = 1'b1;
        if (it.stream_last) res[res.size()-1].stream_end = 1'b1;
      end
      foreach (res[i]) expected_out.push_back(res[i]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_out.size() == 0) begin
        $error("unexpected output transaction: %p", got);
        mismatches++;
        return;
      end
      exp_item = expected_out.pop_front();
      if (got.out_byte !== exp_item.out_byte) begin
        $error("out_byte: expected %02h, got %02h", exp_item.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.byte_valid !== exp_item.byte_valid) begin
        $error("byte_valid: expected %b, got %b", exp_item.byte_valid, got.byte_valid);
        mismatches++;
      end
      if (got.run_last !== exp_item.run_last) begin
        $error("run_last: expected %b, got %b", exp_item.run_last, got.run_last);
        mismatches++;
      end
      if (got.stream_end !== exp_item.stream_end) begin
        $error("stream_end: expected %b, got %b", exp_item.stream_end, got.stream_end);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_out.size();
    endfunction

    function void report_leftover();
      if (expected_out.size() != 0) begin
        $error("%0d expected output transactions never arrived", expected_out.size());
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;

  substitution_scoreboard sb;
  bit          no_idle   = 1'b0;
  bit          hold_req  = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles    = 0;
  logic [7:0]  alph[4];
  logic [63:0] pat_val;
  int unsigned eff_len;
  int unsigned sent;

  stream_find_and_replace_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random back-pressure, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: input transactions feed the predictor, output ones are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  // offer one byte and wait until it is taken
  task automatic send_item(logic [7:0] b, logic last);
    in_item_t    it;
    int unsigned gap;
    gap = 0;
    if (!no_idle)
      while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.data_byte   = b;
    it.stream_last = last;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_seq(logic [7:0] txt[$], bit ends);
    foreach (txt[i]) begin
      send_item(txt[i], ends && (i == txt.size() - 1));
      sent++;
    end
  endtask

  // stop offering and let every expected byte come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0 || out_valid_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write; back-to-back writes go straight from access to setup
  task automatic write_reg(cfg_reg_e r, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(r, v);
  endtask

  task automatic cfg_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(logic [63:0] sp, logic [3:0] sl, logic [63:0] rp, logic [3:0] rl);
    wait_idle();
    write_reg(REG_SEARCH_PATTERN, sp);
    write_reg(REG_SEARCH_LENGTH, {60'd0, sl});
    write_reg(REG_REPLACE_PATTERN, rp);
    write_reg(REG_REPLACE_LENGTH, {60'd0, rl});
    cfg_idle();
    pat_val = sp;
    eff_len = (sl > MAX_PATTERN) ? MAX_PATTERN : sl;
  endtask

  // one stream, built mostly from whole and partial search patterns while the search length is nonzero
  task automatic send_stream(int unsigned target);
    logic [7:0]  txt[$];
    int unsigned pick;
    int unsigned n;
    while (txt.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 40 && eff_len > 0) begin
        for (int i = 0; i < eff_len; i++) txt.push_back(pat_val[8*i +: 8]);
      end else if (pick < 55 && eff_len > 0) begin
        n = $urandom_range(eff_len);
        for (int i = 0; i < n; i++) txt.push_back(pat_val[8*i +: 8]);
      end else if (pick < 85) begin
        txt.push_back(alph[2'($urandom_range(3))]);
      end else begin
        txt.push_back(8'($urandom_range(255)));
      end
    end
    send_seq(txt, 1'b1);
  endtask

  initial begin
    logic [63:0] sp;
    logic [3:0]  sl;
    logic [3:0]  rl;
    int unsigned goal;
    sb = new();
    sent = 0;
    eff_len = 0;
    pat_val = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through after reset, both byte extremes
    send_seq('{8'h00, 8'hff}, 1'b1);

    // a match expanding to the longest replacement, then a short tail
    configure(64'h6261, 4'd2, 64'hffeeddccbbaa9988, 4'd8);
    send_seq('{8'h61, 8'h62}, 1'b1);
    send_seq('{8'h78, 8'h61, 8'h61, 8'h62, 8'h61}, 1'b1);

    // deletion; a stream ending on a deleted match gives a bare end marker
    configure(64'h6261, 4'd2, 64'hffeeddccbbaa9988, 4'd0);
    send_seq('{8'h61, 8'h62}, 1'b1);

    // oversized lengths clamp to eight bytes
    configure(64'h00ff00ff00ff00ff, 4'd15, 64'h0123456789abcdef, 4'd15);
    send_seq('{8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00}, 1'b1);

    // changing the search length drops the bytes held in the window
    send_seq('{8'h11, 8'h22}, 1'b0);
    wait_idle();
    write_reg(REG_SEARCH_LENGTH, 64'd2);
    cfg_idle();
    eff_len = 2;
    send_seq('{8'hff, 8'h00}, 1'b1);

    // random phases, each with its own setting
    for (int ph = 0; ph < 8; ph++) begin
      foreach (alph[i]) alph[i] = 8'($urandom_range(255));
      for (int i = 0; i < 8; i++) sp[8*i +: 8] = alph[2'($urandom_range(3))];
      case (ph)
        0: begin sl = 4'd1;  rl = 4'd0;  end
        1: begin sl = 4'd8;  rl = 4'd8;  end
        2: begin sl = 4'd0;  rl = 4'd3;  end
        3: begin sl = 4'd15; rl = 4'd12; end
        default: begin
          sl = ($urandom_range(3) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
          rl = 4'($urandom_range(15));
        end
      endcase
      configure(sp, sl, {$urandom, $urandom}, rl);
      no_idle = (ph == 1);
      if (ph == 3) hold_req = 1'b1;
      goal = sent + 48;
      while (sent < goal) begin
        send_stream($urandom_range(1, 14));
        // sender waits for the block to drain now and then
        if (ph == 5 && sent < goal - 36) wait_idle();
      end
    end

    // drain
    wait_idle();
    no_idle = 1'b0;
    repeat (16) @(posedge clk_i);
    sb.report_leftover();
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sfr_pkg.sv
sv/stream_find_and_replace_unit.sv
test/tb_stream_find_and_replace_unit.sv
